### hdl/r250_r521_combined_gfsr_unit_assert.svh
// assertion macros shared by the generator modules
`ifndef R250_R521_COMBINED_GFSR_UNIT_ASSERT_SVH
`define R250_R521_COMBINED_GFSR_UNIT_ASSERT_SVH

// same-cycle implication, sampled on the rising clock edge
`define RRG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rrg same-cycle check failed");

// next-cycle implication
`define RRG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rrg next-cycle check failed");

`endif

### hdl/rrg_pkg.sv
package rrg_pkg;

    localparam int WORD_W      = 31;
    localparam int SHORT_AW    = 8;
    localparam int LONG_AW     = 10;
    localparam int FILL_W      = 10;
    localparam int SHORT_DEPTH = 250;
    localparam int LONG_DEPTH  = 521;
    localparam int FILL_TOTAL  = 771;
    localparam int SHORT_LAG   = 147;
    localparam int SHORT_FWD   = 103;
    localparam int LONG_LAG    = 353;
    localparam int LONG_FWD    = 168;
    localparam int SHORT_STEP  = 7;
    localparam int LONG_STEP   = 13;
    localparam int DIAG_COUNT  = 31;

    localparam logic [WORD_W-1:0] TOP_BIT   = 31'h4000_0000;
    localparam logic [WORD_W-1:0] WORD_MASK = 31'h7FFF_FFFF;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_GEN  = 1'b1
    } t_op;

    // one request as issued to the table stage
    typedef struct packed {
        logic                gen;
        logic                ld_short;
        logic                ld_long;
        logic [SHORT_AW-1:0] s_addr;
        logic [SHORT_AW-1:0] s_lag;
        logic [LONG_AW-1:0]  l_addr;
        logic [LONG_AW-1:0]  l_lag;
        logic [WORD_W-1:0]   word;
    } t_issue;

    // force the diagonal bit pattern on slots step*i+3, i below 31
    function automatic logic [WORD_W-1:0] diag_fix(input logic [WORD_W-1:0] word,
                                                   input logic [FILL_W-1:0] k,
                                                   input int step);
        logic [WORD_W-1:0] res;
        res = word;
        for (int i = 0; i < DIAG_COUNT; i++) begin
            if (k == FILL_W'(step * i + 3)) begin
                res = (word & (WORD_MASK >> i)) | (TOP_BIT >> i);
            end
        end
        return res;
    endfunction

endpackage

### hdl/rrg_ram.sv
module rrg_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 250
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

### hdl/rrg_ctrl.sv
`include "r250_r521_combined_gfsr_unit_assert.svh"

module rrg_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  rrg_pkg::t_op                 i_op,
    input  logic [rrg_pkg::WORD_W-1:0]   i_seed,
    output rrg_pkg::t_issue              o_issue
);
    import rrg_pkg::*;

    logic [FILL_W-1:0]   r_fill, n_fill;
    logic [SHORT_AW-1:0] r_sp, n_sp;
    logic [LONG_AW-1:0]  r_lp, n_lp;

    logic [FILL_W-1:0]   p;
    logic [FILL_W-1:0]   k;
    logic                full;
    logic                is_short;
    logic [WORD_W-1:0]   fix_short;
    logic [WORD_W-1:0]   fix_long;

    always_comb begin
        full      = (r_fill >= FILL_W'(FILL_TOTAL));
        p         = full ? '0 : r_fill;
        is_short  = (p < FILL_W'(SHORT_DEPTH));
        k         = p - FILL_W'(SHORT_DEPTH);
        fix_short = diag_fix(i_seed, p, SHORT_STEP);
        fix_long  = diag_fix(i_seed, k, LONG_STEP);

        o_issue = '0;
        n_fill  = r_fill;
        n_sp    = r_sp;
        n_lp    = r_lp;

        case (i_op)
            OP_LOAD: begin
                o_issue.ld_short = is_short;
                o_issue.ld_long  = !is_short;
                o_issue.s_addr   = p[SHORT_AW-1:0];
                o_issue.l_addr   = k;
                o_issue.word     = is_short ? fix_short : fix_long;
                n_fill           = p + FILL_W'(1);
                if (p == '0) begin
                    n_sp = '0;
                    n_lp = '0;
                end
            end
            OP_GEN: begin
                // generate before both tables are full is dropped
                if (full) begin
                    o_issue.gen    = 1'b1;
                    o_issue.s_addr = r_sp;
                    o_issue.s_lag  = (r_sp >= SHORT_AW'(SHORT_LAG)) ?
                                     r_sp - SHORT_AW'(SHORT_LAG) :
                                     r_sp + SHORT_AW'(SHORT_FWD);
                    o_issue.l_addr = r_lp;
                    o_issue.l_lag  = (r_lp >= LONG_AW'(LONG_LAG)) ?
                                     r_lp - LONG_AW'(LONG_LAG) :
                                     r_lp + LONG_AW'(LONG_FWD);
                    n_sp = (r_sp >= SHORT_AW'(SHORT_DEPTH - 1)) ? '0 : r_sp + SHORT_AW'(1);
                    n_lp = (r_lp >= LONG_AW'(LONG_DEPTH - 1)) ? '0 : r_lp + LONG_AW'(1);
                end
            end
            default: begin
                o_issue = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_sp   <= '0;
            r_lp   <= '0;
        end else if (i_accept) begin
            r_fill <= n_fill;
            r_sp   <= n_sp;
            r_lp   <= n_lp;
        end
    end

    `RRG_ASSERT_NOW(a_sp_range, 1'b1, r_sp < SHORT_AW'(SHORT_DEPTH))
    `RRG_ASSERT_NOW(a_lp_range, 1'b1, r_lp < LONG_AW'(LONG_DEPTH))
    `RRG_ASSERT_NEXT(a_fill_cap, r_fill == FILL_W'(FILL_TOTAL) && !(i_accept && i_op == OP_LOAD),
                     r_fill == FILL_W'(FILL_TOTAL))

endmodule

### hdl/r250_r521_combined_gfsr_unit.sv
// a generate request's word passes the stage 1 register and ram read data, then is registered onto
// o_m_tdata by the output register; stage 1 holds while the output register is blocked
// throughput: one request per cycle, load or generate, while the output is drained
// each table is one ram with two registered read ports and one write port
// reset clears the fill count, both pointers and the pipeline valids; table contents
// are undefined until loaded, and generate requests are dropped until 771 loads
`include "r250_r521_combined_gfsr_unit_assert.svh"

module r250_r521_combined_gfsr_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [30:0] seed_word, [31] zero pad
    input  logic        i_s_tuser,   // [0] op: 0 load seed, 1 generate
    // result channel
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata    // [30:0] random_word, [31] zero pad
);
    import rrg_pkg::*;

    // stage 0: control issues ram reads; stage 1: xor, write back, fill output
    t_issue              issue;
    t_issue              r_s1;
    logic                r_s1_valid;
    logic                accept;
    logic                s1_adv;
    logic                rd_en;

    logic [WORD_W-1:0]   s_rd_a, s_rd_b;
    logic [WORD_W-1:0]   l_rd_a, l_rd_b;
    logic [WORD_W-1:0]   s_new, l_new;
    logic                s_we, l_we;
    logic [WORD_W-1:0]   s_wdata, l_wdata;

    logic                r_m_valid;
    logic [WORD_W-1:0]   r_m_data;

    // stage 1 only holds when it carries a word and the output register is blocked
    assign s1_adv     = !(r_s1_valid && r_s1.gen) || !r_m_valid || i_m_tready;
    assign o_s_tready = s1_adv;
    assign accept     = i_s_tvalid && o_s_tready;
    assign rd_en      = accept && issue.gen;

    rrg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_op    (t_op'(i_s_tuser)),
        .i_seed  (i_s_tdata[WORD_W-1:0]),
        .o_issue (issue)
    );

    // short table, lags 250/147
    rrg_ram #(.WIDTH(WORD_W), .DEPTH(SHORT_DEPTH)) u_short_ram (
        .i_clk    (i_clk),
        .i_we     (s_we),
        .i_waddr  (r_s1.s_addr),
        .i_wdata  (s_wdata),
        .i_re     (rd_en),
        .i_raddr_a(issue.s_addr),
        .i_raddr_b(issue.s_lag),
        .o_rdata_a(s_rd_a),
        .o_rdata_b(s_rd_b)
    );

    // long table, lags 521/353
    rrg_ram #(.WIDTH(WORD_W), .DEPTH(LONG_DEPTH)) u_long_ram (
        .i_clk    (i_clk),
        .i_we     (l_we),
        .i_waddr  (r_s1.l_addr),
        .i_wdata  (l_wdata),
        .i_re     (rd_en),
        .i_raddr_a(issue.l_addr),
        .i_raddr_b(issue.l_lag),
        .o_rdata_a(l_rd_a),
        .o_rdata_b(l_rd_b)
    );

    // read data stays put while stage 1 is held, since no new read is issued
    always_comb begin
        s_new   = s_rd_a ^ s_rd_b;
        l_new   = l_rd_a ^ l_rd_b;
        s_we    = r_s1_valid && s1_adv && (r_s1.gen || r_s1.ld_short);
        l_we    = r_s1_valid && s1_adv && (r_s1.gen || r_s1.ld_long);
        s_wdata = r_s1.gen ? s_new : r_s1.word;
        l_wdata = r_s1.gen ? l_new : r_s1.word;
    end

    // stage 1 register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_adv) begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= issue;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (r_s1_valid && r_s1.gen && s1_adv) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && r_s1.gen && s1_adv) begin
            r_m_data <= s_new ^ l_new;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {1'b0, r_m_data};

    // a write-back never lands on an entry being read in the same cycle
    `RRG_ASSERT_NOW(a_short_no_clash, s_we && rd_en,
                    r_s1.s_addr != issue.s_addr && r_s1.s_addr != issue.s_lag)
    `RRG_ASSERT_NOW(a_long_no_clash, l_we && rd_en,
                    r_s1.l_addr != issue.l_addr && r_s1.l_addr != issue.l_lag)
    // a new result only follows a generate leaving stage 1
    `RRG_ASSERT_NOW(a_out_from_gen, r_m_valid && !$past(r_m_valid),
                    $past(r_s1_valid && r_s1.gen))

endmodule

### tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rrg_pkg::*;

    // request budget for loads plus counted generates, and the long receiver hold-off
    localparam int REQUEST_TARGET  = 1950;
    localparam int FIRST_RUN_GENS  = 530;   // enough to wrap the long pointer once
    localparam int HOLD_AT_RESULT  = 150;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_LIMIT     = 5000;
    localparam int SETTLE_CYCLES   = 8;     // a word passes stage 1 and the output register after its request

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata  = '0;   // [30:0] seed_word, [31] zero pad
    logic        i_s_tuser  = 1'b0; // [0] op
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;         // [30:0] random_word, [31] zero pad

    r250_r521_combined_gfsr_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // generator state as the testbench sees it
    logic [WORD_W-1:0]   model_short [SHORT_DEPTH];
    logic [WORD_W-1:0]   model_long  [LONG_DEPTH];
    logic [SHORT_AW-1:0] model_sp   = '0;
    logic [LONG_AW-1:0]  model_lp   = '0;
    logic [FILL_W-1:0]   model_fill = '0;

    // words still owed by the block, oldest first
    logic [WORD_W-1:0] pending_words [$];

    int requests_sent  = 0;
    int loads_accepted = 0;
    int gens_accepted  = 0;
    int gens_dropped   = 0;
    int fills_done     = 0;
    int results_seen   = 0;
    int mismatches     = 0;

    // seed slots 3, 3+stride, ... get a diagonal bit forced, upper bits cleared
    function automatic logic [WORD_W-1:0] seed_with_diagonal(input logic [WORD_W-1:0] seed,
                                                             input int unsigned k,
                                                             input int unsigned stride);
        int unsigned row;
        if (k < 3 || ((k - 3) % stride) != 0)
            return seed;
        row = (k - 3) / stride;
        if (row >= DIAG_COUNT)
            return seed;
        return (seed & (WORD_MASK >> row)) | (TOP_BIT >> row);
    endfunction

    // advance the generator state by one request; returns 1 when a word comes out
    function automatic bit gfsr_model_step(input t_op op, input logic [WORD_W-1:0] seed,
                                           output logic [WORD_W-1:0] word);
        int unsigned slot;
        int unsigned lag_idx;
        logic [WORD_W-1:0] s_new;
        logic [WORD_W-1:0] l_new;
        word = '0;
        if (op == OP_LOAD) begin
            // a load after a complete fill starts over at slot zero
            slot = (model_fill >= FILL_TOTAL) ? 0 : model_fill;
            if (slot == 0) begin
                model_sp = '0;
                model_lp = '0;
            end
            if (slot < SHORT_DEPTH)
                model_short[SHORT_AW'(slot)] = seed_with_diagonal(seed, slot, SHORT_STEP);
            else
                model_long[LONG_AW'(slot - SHORT_DEPTH)] =
                    seed_with_diagonal(seed, slot - SHORT_DEPTH, LONG_STEP);
            model_fill = FILL_W'(slot + 1);
            return 1'b0;
        end
        // generate before both tables are full is dropped
        if (model_fill < FILL_TOTAL)
            return 1'b0;

        lag_idx = (model_sp >= SHORT_LAG) ? model_sp - SHORT_LAG : model_sp + SHORT_FWD;
        s_new = model_short[model_sp] ^ model_short[SHORT_AW'(lag_idx)];
        model_short[model_sp] = s_new;
        model_sp = (model_sp == SHORT_DEPTH - 1) ? '0 : model_sp + 1'b1;

        lag_idx = (model_lp >= LONG_LAG) ? model_lp - LONG_LAG : model_lp + LONG_FWD;
        l_new = model_long[model_lp] ^ model_long[LONG_AW'(lag_idx)];
        model_long[model_lp] = l_new;
        model_lp = (model_lp == LONG_DEPTH - 1) ? '0 : model_lp + 1'b1;

        word = s_new ^ l_new;
        return 1'b1;
    endfunction

    function automatic void note_mismatch(input string what, input logic [WORD_W-1:0] want,
                                          input logic [WORD_W-1:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch (%s) at %0t: expected %h, got %h", what, $time, want, got);
    endfunction

    // seeds lean on the extremes now and then
    function automatic logic [WORD_W-1:0] pick_seed();
        case ($urandom_range(9))
            0:       return '0;
            1:       return WORD_MASK;
            2:       return TOP_BIT >> $urandom_range(30);
            3:       return WORD_MASK ^ (TOP_BIT >> $urandom_range(30));
            default: return WORD_W'($urandom & WORD_MASK);
        endcase
    endfunction

    // offer one request, wait for acceptance, then record what it should produce;
    // a typed expectation overrides the predicted one
    task automatic send_request(input t_op op, input logic [WORD_W-1:0] seed,
                                input bit typed, input bit typed_hit,
                                input logic [WORD_W-1:0] typed_word);
        bit hit;
        logic [WORD_W-1:0] word;
        // random sender idle cycles, about one in seven, except in one long stretch
        while (!(requests_sent >= 1200 && requests_sent < 1500) &&
               $urandom_range(99) < 14) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {1'b0, seed};
        i_s_tuser  <= op;
        do
            @(posedge i_clk);
        while (!o_s_tready);

        // request accepted at this edge
        requests_sent++;
        if (op == OP_LOAD)
            loads_accepted++;
        else if (model_fill < FILL_TOTAL)
            gens_dropped++;
        else
            gens_accepted++;
        hit = gfsr_model_step(op, seed, word);
        if (op == OP_LOAD && model_fill == FILL_TOTAL)
            fills_done++;
        if (typed) begin
            hit  = typed_hit;
            word = typed_word;
        end
        if (hit)
            pending_words.push_back(word);
    endtask

    // directed requests: none of these can yield a word, so the expectation is typed in
    typedef struct {
        t_op               op;
        logic [WORD_W-1:0] seed;
        bit                yields;
        logic [WORD_W-1:0] word;
    } t_directed_row;

    t_directed_row directed_rows [] = '{
        '{OP_GEN,  31'h7FFF_FFFF, 1'b0, '0},  // generate straight after reset, dropped
        '{OP_LOAD, 31'h7FFF_FFFF, 1'b0, '0},  // first load, slot 0, pointers cleared
        '{OP_LOAD, 31'h0000_0000, 1'b0, '0},
        '{OP_LOAD, 31'h0000_0000, 1'b0, '0},
        '{OP_LOAD, 31'h0000_0000, 1'b0, '0},  // slot 3, top diagonal bit forced
        '{OP_LOAD, 31'h7FFF_FFFF, 1'b0, '0},
        '{OP_GEN,  31'h0000_0000, 1'b0, '0},  // generate mid-fill, dropped
        '{OP_LOAD, 31'h2AAA_AAAA, 1'b0, '0},
        '{OP_LOAD, 31'h5555_5555, 1'b0, '0},
        '{OP_LOAD, 31'h4000_0000, 1'b0, '0},
        '{OP_LOAD, 31'h0000_0001, 1'b0, '0},
        '{OP_LOAD, 31'h0000_0000, 1'b0, '0},
        '{OP_LOAD, 31'h7FFF_FFFF, 1'b0, '0},  // slot 10, bit 30 cleared, bit 29 set
        '{OP_LOAD, 31'h1234_5678, 1'b0, '0},
        '{OP_LOAD, 31'h7FFF_FFFF, 1'b0, '0},
        '{OP_LOAD, 31'h0000_0000, 1'b0, '0},
        '{OP_LOAD, 31'h3FFF_FFFF, 1'b0, '0},
        '{OP_LOAD, 31'h0F0F_0F0F, 1'b0, '0},
        '{OP_LOAD, 31'h7FFF_FFFF, 1'b0, '0},
        '{OP_LOAD, 31'h0000_0000, 1'b0, '0},  // slot 17, bit 28 forced on a zero seed
        '{OP_GEN,  31'h5555_5555, 1'b0, '0}   // still far from full, dropped
    };

    // request side: reset, directed table, random fill/generate runs, then the wrap-up
    initial begin : request_source
        int counted;
        int run_gens;
        int gen_target;
        int drain_wait;
        counted    = 0;
        run_gens   = 0;
        gen_target = FIRST_RUN_GENS;
        drain_wait = 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r])
            send_request(directed_rows[r].op, directed_rows[r].seed, 1'b1,
                         directed_rows[r].yields, directed_rows[r].word);

        // mostly whole fills followed by a run of generates; a few dropped
        // generates sprinkled into each fill act as noise
        while (!(counted >= REQUEST_TARGET && run_gens >= 40)) begin
            if (model_fill < FILL_TOTAL) begin
                if ($urandom_range(99) < 3) begin
                    send_request(OP_GEN, WORD_W'($urandom & WORD_MASK), 1'b0, 1'b0, '0);
                end else begin
                    send_request(OP_LOAD, pick_seed(), 1'b0, 1'b0, '0);
                    counted++;
                end
            end else if (run_gens < gen_target) begin
                send_request(OP_GEN, WORD_W'($urandom & WORD_MASK), 1'b0, 1'b0, '0);
                counted++;
                run_gens++;
            end else begin
                // load on a full table restarts the fill
                run_gens   = 0;
                gen_target = $urandom_range(40, 200);
                send_request(OP_LOAD, pick_seed(), 1'b0, 1'b0, '0);
                counted++;
            end
        end
        i_s_tvalid <= 1'b0;

        while (pending_words.size() != 0 && drain_wait < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_wait++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (pending_words.size() != 0) begin
            mismatches += pending_words.size();
            $display("%0d expected words never arrived", pending_words.size());
        end

        $display("covered %0d loads over %0d complete fills, %0d generates, %0d dropped",
                 loads_accepted, fills_done, gens_accepted, gens_dropped);
        $display("checked %0d output words, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // result side: check each accepted word, random stalls, one long hold-off
    initial begin : result_sink
        int hold_left;
        bit hold_done;
        logic [WORD_W-1:0] want;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                results_seen++;
                if (pending_words.size() == 0) begin
                    note_mismatch("unexpected word", '0, o_m_tdata[WORD_W-1:0]);
                end else begin
                    want = pending_words.pop_front();
                    if (o_m_tdata[WORD_W-1:0] !== want)
                        note_mismatch("random_word", want, o_m_tdata[WORD_W-1:0]);
                end
            end
            // long hold-off while generates keep coming, so the input backs up
            if (!hold_done && results_seen == HOLD_AT_RESULT) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (results_seen >= 300 && results_seen < 480) begin
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= ($urandom_range(99) >= 14);
            end
        end
    end

    // run limit, far beyond the slowest correct run
    initial begin : run_limit
        #4_000_000;
        $display("timeout with %0d words still expected", pending_words.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
